FILE: rtl/urtm_pkg.sv
`default_nettype none

package urtm_pkg;

  localparam int TOF_W  = 16;
  localparam int DIST_W = 11;
  localparam int TONE_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // largest distance a 16-bit flight time can give
  localparam int MAX_DIST = 1114;

  // floor(t*17/1000) == (t * DIST_RECIP) >> DIST_SHIFT for every 16-bit t
  localparam int DIST_SHIFT = 30;
  localparam int RECIP_W    = 25;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 25'd18253612;

  // mapping divider: |(avg - rlo) * (thi - tlo)| < 2^27, |rhi - rlo| < 2^11
  localparam int QUO_W = 27;
  localparam int DEN_W = 11;
  localparam int CNT_W = 5;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] CFG_TONE_LOW   = 2'd2;
  localparam logic [IDX_W-1:0] CFG_TONE_HIGH  = 2'd3;

  localparam logic [DIST_W-1:0] RST_RANGE_LOW  = 11'd5;
  localparam logic [DIST_W-1:0] RST_RANGE_HIGH = 11'd350;
  localparam logic [TONE_W-1:0] RST_TONE_LOW   = 16'd100;
  localparam logic [TONE_W-1:0] RST_TONE_HIGH  = 16'd4000;

  typedef struct packed {
    logic [DIST_W-1:0] range_low;
    logic [DIST_W-1:0] range_high;
    logic [TONE_W-1:0] tone_low;
    logic [TONE_W-1:0] tone_high;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_AVG,
    ST_MAP,
    ST_START,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/urtm_front.sv
`default_nettype none

module urtm_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [urtm_pkg::TOF_W-1:0]  in_flight_time_us,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [urtm_pkg::DIST_W-1:0]      push_dist
);
  import urtm_pkg::*;

  localparam int PROD_W = TOF_W + RECIP_W;

  logic              vld_r;
  logic [TOF_W-1:0]  tof_r;
  logic [PROD_W-1:0] prod;
  logic              take;

  assign in_ready = !vld_r || push_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tof_r <= in_flight_time_us;
    end
  end

  assign prod       = PROD_W'(tof_r) * PROD_W'(DIST_RECIP);
  assign push_dist  = prod[DIST_SHIFT +: DIST_W];
  assign push_valid = vld_r;

endmodule

`default_nettype wire

FILE: rtl/urtm_queue.sv
`default_nettype none

module urtm_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_valid,
  output logic                             wr_ready,
  input  wire logic [urtm_pkg::DIST_W-1:0] wr_data,
  output logic                             rd_valid,
  input  wire logic                        rd_pop,
  output logic [urtm_pkg::DIST_W-1:0]      rd_data
);
  import urtm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [DIST_W-1:0] slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [PTR_W:0]    count_r;
  logic              push;
  logic              pop;

  assign wr_ready = count_r != (PTR_W+1)'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_data  = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/urtm_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module urtm_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire urtm_pkg::div_req_t req,
  output urtm_pkg::div_rsp_t      rsp
);
  import urtm_pkg::*;

  logic [DEN_W:0]   rem_r;
  logic [QUO_W-1:0] dq_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DEN_W-1:0], dq_r[QUO_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dq_r  <= req.dividend;
      den_r <= req.divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
      dq_r  <= {dq_r[QUO_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rsp = '{done: done_r, quotient: dq_r};

endmodule

`default_nettype wire

FILE: rtl/urtm_back.sv
`default_nettype none

module urtm_back #(
  parameter int WINDOW = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire urtm_pkg::cfg_t              cfg,
  input  wire logic                        q_valid,
  input  wire logic [urtm_pkg::DIST_W-1:0] q_dist,
  output logic                             q_pop,
  output urtm_pkg::div_req_t               div_req,
  input  wire urtm_pkg::div_rsp_t          div_rsp,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [urtm_pkg::DIST_W-1:0]      out_distance_mm,
  output logic [urtm_pkg::DIST_W-1:0]      out_average_mm,
  output logic [urtm_pkg::TONE_W-1:0]      out_tone_hz
);
  import urtm_pkg::*;

  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = $clog2(WINDOW * MAX_DIST + 1);
  // sum / WINDOW as multiply by rounded-up reciprocal; shift leaves error < 1/WINDOW
  localparam int AVG_SHIFT = SUM_W + SLOT_W + 1;
  localparam logic [63:0] AVG_RECIP_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [AVG_SHIFT:0] AVG_RECIP = AVG_RECIP_FULL[AVG_SHIFT:0];
  localparam int AVG_PW    = SUM_W + AVG_SHIFT + 1;
  localparam int NUM_W     = QUO_W + 2;
  localparam int DIFF_W    = DIST_W + 1;
  localparam int SPAN_W    = TONE_W + 1;
  localparam int Q_W       = QUO_W + 3;

  back_state_t state_r, state_nxt;

  logic [DIST_W-1:0] store_mem [WINDOW];
  logic [WINDOW-1:0] filled_r;
  logic [DIST_W-1:0] rd_data_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DIST_W-1:0] dist_r;
  logic [AVG_PW-1:0] avg_prod_r;
  logic [DIST_W-1:0] avg_r;
  logic signed [NUM_W-1:0] num_r;
  logic              neg_r;
  logic [DEN_W-1:0]  den_r;
  logic [TONE_W-1:0] tone_r;
  logic              out_valid_r;

  logic              mem_re, mem_we, load_out;
  logic [DIST_W-1:0] old_dist;
  logic [DIST_W-1:0] avg_now;
  logic signed [DIFF_W-1:0] diff_a, diff_r;
  logic signed [SPAN_W-1:0] span_t;
  logic [NUM_W-1:0]  num_mag;
  logic signed [Q_W-1:0] q_val, t_lo, t_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    q_pop            = 1'b0;
    mem_re           = 1'b0;
    mem_we           = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num_mag[QUO_W-1:0];
    div_req.divisor  = den_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mem_re    = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we    = 1'b1;
        state_nxt = ST_AVG;
      end
      ST_AVG: state_nxt = ST_MAP;
      ST_MAP: begin
        // equal sensor limits skip the divide
        state_nxt = (cfg.range_low == cfg.range_high) ? ST_OUT : ST_START;
      end
      ST_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // window store: one read, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[slot_r] <= dist_r;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[slot_r];
    end
  end

  assign old_dist = filled_r[slot_r] ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      slot_r   <= '0;
      sum_r    <= '0;
    end else if (mem_we) begin
      filled_r[slot_r] <= 1'b1;
      slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      sum_r  <= sum_r - SUM_W'(old_dist) + SUM_W'(dist_r);
    end
  end

  assign avg_now = avg_prod_r[AVG_SHIFT +: DIST_W];
  assign diff_a  = $signed({1'b0, avg_now}) - $signed({1'b0, cfg.range_low});
  assign diff_r  = $signed({1'b0, cfg.range_high}) - $signed({1'b0, cfg.range_low});
  assign span_t  = $signed({1'b0, cfg.tone_high}) - $signed({1'b0, cfg.tone_low});
  assign num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);

  assign t_lo  = $signed(Q_W'(cfg.tone_low));
  assign t_hi  = $signed(Q_W'(cfg.tone_high));
  assign q_val = (neg_r ? -$signed(Q_W'(div_rsp.quotient))
                        :  $signed(Q_W'(div_rsp.quotient))) + t_lo;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dist_r <= q_dist;
    end
    if (state_r == ST_AVG) begin
      avg_prod_r <= AVG_PW'(sum_r) * AVG_PW'(AVG_RECIP);
    end
    if (state_r == ST_MAP) begin
      avg_r  <= avg_now;
      num_r  <= NUM_W'(diff_a) * NUM_W'(span_t);
      neg_r  <= diff_a[DIFF_W-1] ^ span_t[SPAN_W-1] ^ diff_r[DIFF_W-1];
      den_r  <= diff_r[DIFF_W-1] ? DEN_W'(-diff_r) : DEN_W'(diff_r);
      tone_r <= cfg.tone_low;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      // ceiling test first, so inverted tone limits still land on a limit
      priority if (q_val > t_hi) begin
        tone_r <= cfg.tone_high;
      end else if (q_val < t_lo) begin
        tone_r <= cfg.tone_low;
      end else begin
        tone_r <= q_val[TONE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_distance_mm <= dist_r;
      out_average_mm  <= avg_r;
      out_tone_hz     <= tone_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_range_tone_mapper.sv
`default_nettype none

// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    in_flight_time_us[15:0]
// out_     output     out_valid / out_ready  out_distance_mm, out_average_mm, out_tone_hz
// cfg_     input      cfg_we (no wait)       cfg_index[1:0], cfg_data[15:0]
//
// Items pass the back end one at a time; the tone map uses the 27-step restoring divider,
// and when the sensor limits are equal the divide is skipped.
// The front converts time to distance in one multiply and queues up to two beats,
// so input is taken while the back end works or a result waits on out_ready.
// rst_n is synchronous; reset clears the window and restores the register defaults.
module ultrasonic_range_tone_mapper #(
  parameter int WINDOW = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [urtm_pkg::TOF_W-1:0]  in_flight_time_us,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [urtm_pkg::DIST_W-1:0]      out_distance_mm,
  output logic [urtm_pkg::DIST_W-1:0]      out_average_mm,
  output logic [urtm_pkg::TONE_W-1:0]      out_tone_hz,
  input  wire logic                        cfg_we,
  input  wire logic [urtm_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [urtm_pkg::CFG_W-1:0]  cfg_data
);
  import urtm_pkg::*;

  cfg_t              cfg_r;
  logic              push_valid, push_ready;
  logic [DIST_W-1:0] push_dist;
  logic              q_valid, q_pop;
  logic [DIST_W-1:0] q_dist;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_low  <= RST_RANGE_LOW;
      cfg_r.range_high <= RST_RANGE_HIGH;
      cfg_r.tone_low   <= RST_TONE_LOW;
      cfg_r.tone_high  <= RST_TONE_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_LOW:  cfg_r.range_low  <= cfg_data[DIST_W-1:0];
        CFG_RANGE_HIGH: cfg_r.range_high <= cfg_data[DIST_W-1:0];
        CFG_TONE_LOW:   cfg_r.tone_low   <= cfg_data[TONE_W-1:0];
        CFG_TONE_HIGH:  cfg_r.tone_high  <= cfg_data[TONE_W-1:0];
        default: ;
      endcase
    end
  end

  urtm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_flight_time_us (in_flight_time_us),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_dist         (push_dist)
  );

  urtm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_dist),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_dist)
  );

  urtm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  urtm_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_dist          (q_dist),
    .q_pop           (q_pop),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_distance_mm (out_distance_mm),
    .out_average_mm  (out_average_mm),
    .out_tone_hz     (out_tone_hz)
  );

endmodule

`default_nettype wire

FILE: test/ultrasonic_range_tone_mapper_checker.sv
`default_nettype none

module ultrasonic_range_tone_mapper_checker #(
  parameter int WINDOW = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [urtm_pkg::TOF_W-1:0]  in_flight_time_us,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [urtm_pkg::DIST_W-1:0] out_distance_mm,
  input  wire logic [urtm_pkg::DIST_W-1:0] out_average_mm,
  input  wire logic [urtm_pkg::TONE_W-1:0] out_tone_hz,
  input  wire logic                        cfg_we,
  input  wire logic [urtm_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [urtm_pkg::CFG_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               pending,
  output int                               results
);
  timeunit 1ns;
  timeprecision 1ps;
  import urtm_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] avg;
    logic [TONE_W-1:0] tone;
  } reading_t;

  reading_t          expected_readings[$];
  logic [DIST_W-1:0] window_ring [WINDOW];
  int unsigned       window_total;
  int unsigned       ring_pos;
  cfg_t              regs;
  int                err_count;
  int                n_results;

  function automatic logic [TONE_W-1:0] map_to_tone(input logic [DIST_W-1:0] avg);
    longint a, rlo, rhi, tlo, thi, q;
    a   = avg;
    rlo = regs.range_low;
    rhi = regs.range_high;
    tlo = regs.tone_low;
    thi = regs.tone_high;
    if (rlo == rhi) return regs.tone_low;
    // signed divide truncates toward zero
    q = (a - rlo) * (thi - tlo) / (rhi - rlo) + tlo;
    // ceiling is tested first so inverted tone limits still land on a limit
    if (q > thi) q = thi;
    else if (q < tlo) q = tlo;
    return q[TONE_W-1:0];
  endfunction

  function automatic reading_t predict_reading(input logic [TOF_W-1:0] tof);
    int unsigned mm;
    int unsigned slot;
    reading_t    r;
    mm = tof;
    mm = mm * 17 / 1000;
    slot = (ring_pos >= WINDOW) ? 0 : ring_pos;
    window_total = window_total - window_ring[slot] + mm;
    window_ring[slot] = mm[DIST_W-1:0];
    ring_pos = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    r.distance = mm[DIST_W-1:0];
    r.avg      = DIST_W'(window_total / WINDOW);
    r.tone     = map_to_tone(r.avg);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      regs = '{RST_RANGE_LOW, RST_RANGE_HIGH, RST_TONE_LOW, RST_TONE_HIGH};
      foreach (window_ring[i]) window_ring[i] = '0;
      window_total = 0;
      ring_pos = 0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LOW:  regs.range_low  = cfg_data[DIST_W-1:0];
          CFG_RANGE_HIGH: regs.range_high = cfg_data[DIST_W-1:0];
          CFG_TONE_LOW:   regs.tone_low   = cfg_data[TONE_W-1:0];
          CFG_TONE_HIGH:  regs.tone_high  = cfg_data[TONE_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting, so a beat taken this edge can't match a result
      if (out_valid && out_ready) begin
        got = '{out_distance_mm, out_average_mm, out_tone_hz};
        n_results++;
        if (expected_readings.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("reading %0d arrived with none pending: dist %0d avg %0d tone %0d",
                     n_results, got.distance, got.avg, got.tone);
        end else begin
          want = expected_readings.pop_front();
          if (got.distance !== want.distance || got.avg !== want.avg ||
              got.tone !== want.tone) begin
            err_count++;
            if (err_count <= 10)
              $display("reading %0d: want dist %0d avg %0d tone %0d, got %0d %0d %0d",
                       n_results, want.distance, want.avg, want.tone,
                       got.distance, got.avg, got.tone);
          end
        end
      end
      if (in_valid && in_ready)
        expected_readings.push_back(predict_reading(in_flight_time_us));
    end
    mismatches <= err_count;
    pending    <= expected_readings.size();
    results    <= n_results;
  end

endmodule

`default_nettype wire

FILE: test/ultrasonic_range_tone_mapper_test.sv
`default_nettype none

module ultrasonic_range_tone_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import urtm_pkg::*;

  localparam int WINDOW            = 15;
  localparam int LIMIT_CYCLES      = 1_000_000;
  localparam int HOLD_CYCLES       = 300;
  localparam int SETTINGS_PER_MODE = 8;
  localparam int BEATS_PER_SETTING = 60;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TOF_W-1:0]  in_flight_time_us = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DIST_W-1:0] out_distance_mm;
  logic [DIST_W-1:0] out_average_mm;
  logic [TONE_W-1:0] out_tone_hz;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  int   mismatches;
  int   pending;
  int   results;
  int   send_idle = 0;
  int   recv_idle = 0;
  logic hold_off = 1'b0;
  logic hold_start = 1'b0;
  int   cycle_count = 0;
  int   beats_sent = 0;
  int   reg_writes = 0;
  int   settings_used = 0;

  ultrasonic_range_tone_mapper #(.WINDOW(WINDOW)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_flight_time_us (in_flight_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance_mm   (out_distance_mm),
    .out_average_mm    (out_average_mm),
    .out_tone_hz       (out_tone_hz),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  ultrasonic_range_tone_mapper_checker #(.WINDOW(WINDOW)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_flight_time_us (in_flight_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance_mm   (out_distance_mm),
    .out_average_mm    (out_average_mm),
    .out_tone_hz       (out_tone_hz),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .pending           (pending),
    .results           (results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timed out after %0d cycles, %0d readings still pending", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);

  // one long output stall while the sender keeps pushing
  initial begin : long_hold
    int held;
    while (!hold_start) @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_beat(input logic [TOF_W-1:0] tof);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_flight_time_us <= tof;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic drain_block(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] rh,
                                input logic [CFG_W-1:0] tl, input logic [CFG_W-1:0] th);
    drain_block(8);
    write_reg(CFG_RANGE_LOW, rl);
    write_reg(CFG_RANGE_HIGH, rh);
    write_reg(CFG_TONE_LOW, tl);
    write_reg(CFG_TONE_HIGH, th);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // junk above bit 10 must be dropped by the range registers
  function automatic logic [CFG_W-1:0] range_word(input int val);
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    w[DIST_W-1:0] = DIST_W'(val);
    return w;
  endfunction

  task automatic random_settings();
    int rl, rh;
    case ($urandom_range(0, 9))
      0: apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                        CFG_W'($urandom));
      1: begin
        rl = $urandom_range(0, 2047);
        apply_settings(range_word(rl), range_word(rl), CFG_W'($urandom), CFG_W'($urandom));
      end
      2: apply_settings(range_word($urandom_range(0, 1) * 2047),
                        range_word($urandom_range(0, 1) * 2047),
                        CFG_W'($urandom_range(0, 1) * 65535),
                        CFG_W'($urandom_range(0, 1) * 65535));
      3: begin
        rl = $urandom_range(300, 1200);
        rh = $urandom_range(0, rl);
        apply_settings(range_word(rl), range_word(rh), CFG_W'($urandom), CFG_W'($urandom));
      end
      default: begin
        rl = $urandom_range(0, 600);
        rh = $urandom_range(rl, 1200);
        apply_settings(range_word(rl), range_word(rh), CFG_W'($urandom), CFG_W'($urandom));
      end
    endcase
  endtask

  function automatic logic [TOF_W-1:0] pick_flight_time();
    case ($urandom_range(0, 5))
      0: return TOF_W'($urandom_range(0, 7000));
      1: return TOF_W'($urandom_range(64000, 65535));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return TOF_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [TOF_W-1:0] reset_cfg_tofs [10];
    logic [TOF_W-1:0] equal_tofs [3];
    logic [TOF_W-1:0] swap_tofs [4];
    logic [TOF_W-1:0] wide_tofs [4];
    int mode, s, k;
    // 58/59 straddle the first millimetre step
    reset_cfg_tofs = '{16'd0, 16'hFFFF, 16'd58, 16'd59, 16'hFFFE, 16'h5555, 16'hAAAA,
                       16'd20000, 16'd30000, 16'd1000};
    equal_tofs = '{16'd0, 16'hFFFF, 16'd12000};
    swap_tofs  = '{16'd0, 16'hFFFF, 16'd30000, 16'd10000};
    wide_tofs  = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd40000};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 23;
    recv_idle = 61;

    // register defaults from reset
    foreach (reset_cfg_tofs[i]) send_beat(reset_cfg_tofs[i]);
    // equal sensor limits
    apply_settings(16'd200, 16'd200, 16'd300, 16'd5000);
    foreach (equal_tofs[i]) send_beat(equal_tofs[i]);
    // inverted tone limits
    apply_settings(16'd0, 16'd1114, 16'd5000, 16'd200);
    foreach (swap_tofs[i]) send_beat(swap_tofs[i]);
    // inverted sensor limits, upper data bits set on the range words
    apply_settings(16'hF800 | 16'd1000, 16'hA800 | 16'd50, 16'd100, 16'd4000);
    foreach (swap_tofs[i]) send_beat(swap_tofs[i]);
    // widest ranges on both sides
    apply_settings(16'd0, 16'd2047, 16'd0, 16'hFFFF);
    foreach (wide_tofs[i]) send_beat(wide_tofs[i]);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 23; recv_idle = 61; end
        1: begin send_idle = 61; recv_idle = 23; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (s = 0; s < SETTINGS_PER_MODE; s++) begin
        random_settings();
        if (mode == 2 && s == 0) hold_start <= 1'b1;
        for (k = 0; k < BEATS_PER_SETTING; k++) send_beat(pick_flight_time());
      end
    end

    drain_block(40);

    $display("sent %0d flight times over %0d register settings (%0d writes), checked %0d readings",
             beats_sent, settings_used, reg_writes, results);
    $display("idle mixes 23/61, 61/23 and none, plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
